@@ rtl/char_stream_lexer_assert.svh @@
// assertion macros shared by the lexer checker
// no dependencies; every macro takes clock and active-low reset explicitly
`ifndef CHAR_STREAM_LEXER_ASSERT_SVH
`define CHAR_STREAM_LEXER_ASSERT_SVH

// expression holds on every clock edge out of reset
`define CSLX_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lexer check failed");

// consequent holds in the same cycle as the antecedent
`define CSLX_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// consequent holds in the cycle after the antecedent
`define CSLX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

@@ rtl/cslx_pkg.sv @@
// shared types and constants for the character stream lexer
// no dependencies
package cslx_pkg;

    // longest token text kept, in characters (1 to 8)
    localparam int unsigned MaxLen = 8;

    localparam int unsigned TextW  = 64;
    localparam int unsigned LenW   = 4;
    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW  = 2;
    localparam int unsigned QCntW  = 3;

    // packed keyword text, first character in the low byte
    localparam logic [TextW-1:0] KwReturn = 64'h0000_6E72_7574_6572;
    localparam logic [LenW-1:0]  KwReturnLen = 4'd6;
    localparam logic [TextW-1:0] KwLet    = 64'h0000_0000_0074_656C;
    localparam logic [LenW-1:0]  KwLetLen = 4'd3;

    typedef enum logic [2:0] {
        KIND_RETURN = 3'd0,
        KIND_LET    = 3'd1,
        KIND_VAR    = 3'd2,
        KIND_INT    = 3'd3,
        KIND_SEMI   = 3'd4,
        KIND_EQUAL  = 3'd5,
        KIND_PLUS   = 3'd6,
        KIND_MINUS  = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_WORD   = 2'd1,
        MODE_NUMBER = 2'd2
    } t_mode;

    typedef struct packed {
        t_kind             kind;
        logic [TextW-1:0]  text;
        logic [LenW-1:0]   len;
        logic              truncated;
        logic              last;
    } t_token;

endpackage

@@ rtl/char_stream_lexer.sv @@
// character stream lexer: one source byte in per beat, tokens out
// uses cslx_pkg for token kinds, scan modes and the token record
// a token beat is written into the result queue on the byte that completes it
// throughput: one byte per cycle; one token beat leaves per cycle while i_ready holds,
//   from a 4-entry queue, and the input stalls while three or more token beats wait
// reset (synchronous, active low) drops the pending token and empties the queue
module char_stream_lexer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_token_kind,
    output logic [63:0] o_token_text,
    output logic [3:0]  o_text_length,
    output logic        o_truncated,
    output logic        o_last
);

    // pending token state
    cslx_pkg::t_mode                 r_mode, n_mode;
    logic [cslx_pkg::TextW-1:0]      r_text, n_text;
    logic [cslx_pkg::LenW-1:0]       r_count, n_count;
    logic                            r_ovf, n_ovf;

    // result queue
    cslx_pkg::t_token                r_q [cslx_pkg::QDepth];
    logic [cslx_pkg::QPtrW-1:0]      r_wr_ptr, r_rd_ptr;
    logic [cslx_pkg::QCntW-1:0]      r_q_count, n_q_count;

    logic                            in_beat, out_beat;
    cslx_pkg::t_token                res0, res1;
    logic [1:0]                      n_res;
    cslx_pkg::t_token                flush_tok;
    logic                            flush_has;
    logic                            is_letter, is_digit;
    logic                            punct_has;
    cslx_pkg::t_kind                 punct_kind;
    logic [cslx_pkg::TextW-1:0]      base_text;
    logic [cslx_pkg::LenW-1:0]       base_count;
    logic                            base_ovf;

    function automatic logic [cslx_pkg::QCntW-1:0] QCntExt(input logic [1:0] v);
        return {1'b0, v};
    endfunction

    function automatic logic [cslx_pkg::QPtrW-1:0] QPtrExt(input logic [1:0] v);
        return v;
    endfunction

    assign in_beat  = i_valid && o_ready;
    assign out_beat = o_valid && i_ready;
    assign o_ready  = (r_q_count < cslx_pkg::QCntW'(cslx_pkg::QDepth - 1));
    assign o_valid  = (r_q_count != '0);

    assign o_token_kind  = r_q[r_rd_ptr].kind;
    assign o_token_text  = r_q[r_rd_ptr].text;
    assign o_text_length = r_q[r_rd_ptr].len;
    assign o_truncated   = r_q[r_rd_ptr].truncated;
    assign o_last        = r_q[r_rd_ptr].last;

    // character class
    always_comb begin
        is_letter  = 1'b0;
        is_digit   = 1'b0;
        punct_has  = 1'b0;
        punct_kind = cslx_pkg::KIND_SEMI;
        case (i_ch) inside
            [8'h41:8'h5A], [8'h61:8'h7A]: is_letter = 1'b1;
            [8'h30:8'h39]:                is_digit  = 1'b1;
            8'h3B: begin
                punct_has  = 1'b1;
                punct_kind = cslx_pkg::KIND_SEMI;
            end
            8'h3D: begin
                punct_has  = 1'b1;
                punct_kind = cslx_pkg::KIND_EQUAL;
            end
            8'h2B: begin
                punct_has  = 1'b1;
                punct_kind = cslx_pkg::KIND_PLUS;
            end
            8'h2D: begin
                punct_has  = 1'b1;
                punct_kind = cslx_pkg::KIND_MINUS;
            end
            default: ;
        endcase
    end

    // token that the pending text would make if flushed now
    always_comb begin
        flush_has           = (r_mode == cslx_pkg::MODE_WORD) ||
                              (r_mode == cslx_pkg::MODE_NUMBER);
        flush_tok.kind      = cslx_pkg::KIND_VAR;
        flush_tok.text      = r_text;
        flush_tok.len       = r_count;
        flush_tok.truncated = r_ovf;
        flush_tok.last      = 1'b0;
        if (r_mode == cslx_pkg::MODE_NUMBER) begin
            flush_tok.kind = cslx_pkg::KIND_INT;
        end else if (!r_ovf && r_count == cslx_pkg::KwReturnLen &&
                     r_text == cslx_pkg::KwReturn) begin
            flush_tok.kind = cslx_pkg::KIND_RETURN;
            flush_tok.text = '0;
            flush_tok.len  = '0;
        end else if (!r_ovf && r_count == cslx_pkg::KwLetLen &&
                     r_text == cslx_pkg::KwLet) begin
            flush_tok.kind = cslx_pkg::KIND_LET;
            flush_tok.text = '0;
            flush_tok.len  = '0;
        end
    end

    // next pending state and the results of this beat
    always_comb begin
        n_mode     = r_mode;
        n_text     = r_text;
        n_count    = r_count;
        n_ovf      = r_ovf;
        res0       = flush_tok;
        res1       = '0;
        res1.kind  = punct_kind;
        n_res      = 2'd0;
        base_text  = '0;
        base_count = '0;
        base_ovf   = 1'b0;
        if (in_beat) begin
            if (!i_end_of_input && (is_letter || is_digit) &&
                ((is_letter && r_mode == cslx_pkg::MODE_WORD) ||
                 (is_digit && r_mode == cslx_pkg::MODE_NUMBER))) begin
                // same kind: extend the pending token
                base_text  = r_text;
                base_count = r_count;
                base_ovf   = r_ovf;
            end else begin
                // anything else ends the pending token
                n_res = flush_has ? 2'd1 : 2'd0;
            end
            if (!i_end_of_input && (is_letter || is_digit)) begin
                n_mode = is_letter ? cslx_pkg::MODE_WORD : cslx_pkg::MODE_NUMBER;
                n_text = base_text;
                if (base_count < cslx_pkg::LenW'(cslx_pkg::MaxLen)) begin
                    for (int b = 0; b < 8; b++) begin
                        if (base_count[2:0] == 3'(b)) begin
                            n_text[8*b +: 8] = i_ch;
                        end
                    end
                    n_count = base_count + 1'b1;
                    n_ovf   = base_ovf;
                end else begin
                    n_count = base_count;
                    n_ovf   = 1'b1;
                end
            end else begin
                n_mode  = cslx_pkg::MODE_NONE;
                n_text  = '0;
                n_count = '0;
                n_ovf   = 1'b0;
                if (!i_end_of_input && punct_has) begin
                    if (flush_has) begin
                        n_res = 2'd2;
                    end else begin
                        res0  = res1;
                        n_res = 2'd1;
                    end
                end
            end
        end
        if (n_res == 2'd2) begin
            res1.last = 1'b1;
        end else begin
            res0.last = 1'b1;
        end
    end

    // queue occupancy
    always_comb begin
        n_q_count = r_q_count + QCntExt(n_res) - (out_beat ? 3'd1 : 3'd0);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= cslx_pkg::MODE_NONE;
            r_text    <= '0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_q_count <= '0;
        end else begin
            r_mode    <= n_mode;
            r_text    <= n_text;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_wr_ptr  <= r_wr_ptr + QPtrExt(n_res);
            r_rd_ptr  <= r_rd_ptr + (out_beat ? 2'd1 : 2'd0);
            r_q_count <= n_q_count;
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (n_res != 2'd0) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (n_res == 2'd2) begin
            r_q[r_wr_ptr + 2'd1] <= res1;
        end
    end

endmodule

@@ rtl/cslx_checker.sv @@
// port-level checks for the character stream lexer, bound to the top level
// uses char_stream_lexer_assert.svh and cslx_pkg
`include "char_stream_lexer_assert.svh"

module cslx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_token_kind,
    input logic [63:0] o_token_text,
    input logic [3:0]  o_text_length,
    input logic        o_truncated,
    input logic        o_last
);

    logic kw_or_punct;
    assign kw_or_punct = (o_token_kind != cslx_pkg::KIND_VAR) &&
                         (o_token_kind != cslx_pkg::KIND_INT);

    // a stalled beat stays put
    `CSLX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_token_kind) && $stable(o_token_text) && $stable(o_text_length) && $stable(o_last))

    // keywords and punctuation carry no text
    `CSLX_ASSERT_IMPLIES(a_no_text, i_clk, i_rst_n, o_valid && kw_or_punct, o_token_text == '0 && o_text_length == '0 && !o_truncated)

    // kept text never exceeds the limit
    `CSLX_ASSERT_IMPLIES(a_len_max, i_clk, i_rst_n, o_valid, o_text_length <= 4'(cslx_pkg::MaxLen))

    // truncation only happens once the text is full
    `CSLX_ASSERT_IMPLIES(a_trunc_full, i_clk, i_rst_n, o_valid && o_truncated, o_text_length == 4'(cslx_pkg::MaxLen))

    // a word or number beat always carries at least one character
    `CSLX_ASSERT_IMPLIES(a_text_nonempty, i_clk, i_rst_n, o_valid && !kw_or_punct, o_text_length != '0 && o_token_text[7:0] != '0)

endmodule

bind char_stream_lexer cslx_checker u_cslx_checker (.*);
